[hw/rtl/tsor_pkg.sv]
// shared constants and helpers for the tiled surface offset rebase block
package tsor_pkg;

    localparam int RectW     = 14;
    localparam int PitchW    = 18;
    localparam int FmtW      = 3;
    localparam int AdjW      = 33;
    localparam int OffW      = 5;
    localparam int BlkW      = 4;   // log2 of block size
    localparam int TileRowsW = 5;   // log2 of tile height in rows
    localparam int TileBytesW = 7;  // log2 of tile row width in bytes
    localparam int PageW     = 12;  // log2 of page size in bytes

    localparam int TilesYW   = RectW - TileRowsW;        // 9
    localparam int UvTilesYW = RectW - TileRowsW - 1;    // 8
    localparam int PitchTW   = PitchW - TileBytesW;      // 11
    localparam int TilesXW   = RectW - TileRowsW;        // widest tile column count

    typedef logic [FmtW-1:0] t_fmt;
    typedef logic [1:0]      t_px_shift;

    localparam t_fmt FMT_RGB4     = 3'd0;
    localparam t_fmt FMT_YUV2     = 3'd1;
    localparam t_fmt FMT_PLANAR2  = 3'd2;
    localparam t_fmt FMT_PLANAR1  = 3'd3;
    localparam t_fmt FMT_OTHER    = 3'd4;

    // log2 of bytes per pixel
    function automatic t_px_shift px_shift(input t_fmt fmt);
        t_px_shift s;
        case (fmt)
            FMT_RGB4:    s = 2'd2;
            FMT_YUV2:    s = 2'd1;
            FMT_PLANAR2: s = 2'd1;
            default:     s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/tiled_surface_offset_rebase.sv]
// top level: rebases a fill rectangle on a y-tiled surface into tile, block and pixel offsets
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  request  | start, busy (always low)   | i_fill_enable, i_rect_*, i_row_pitch, ...
//  result   | o_strobe, one cycle        | o_valid_res, o_y_*, o_uv_*, o_block_*, o_new_*
//
// one request per cycle; each result passes through the input register, then the result
// register, and is strobed and taken while it sits there. the tile multipliers sit in
// the single logic stage between the two.
// synchronous active-low reset clears both stage flags; no result leaves during reset.
// the receiver cannot stall, so busy stays low.
module tiled_surface_offset_rebase
    import tsor_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_fill_enable,
    input  logic [RectW-1:0]  i_rect_left,
    input  logic [RectW-1:0]  i_rect_top,
    input  logic [RectW-1:0]  i_rect_right,
    input  logic [RectW-1:0]  i_rect_bottom,
    input  logic [PitchW-1:0] i_row_pitch,
    input  logic [RectW-1:0]  i_surface_height,
    input  logic [FmtW-1:0]   i_format_code,
    output logic              o_strobe,
    output logic              o_valid_res,
    output logic [AdjW-1:0]   o_y_base_adjust,
    output logic [OffW-1:0]   o_y_offset_x,
    output logic [OffW-1:0]   o_y_offset_y,
    output logic [AdjW-1:0]   o_uv_base_adjust,
    output logic [OffW-1:0]   o_uv_offset_x,
    output logic [OffW-1:0]   o_uv_offset_y,
    output logic [BlkW-1:0]   o_block_left,
    output logic [BlkW-1:0]   o_block_top,
    output logic [RectW-1:0]  o_new_width,
    output logic [RectW-1:0]  o_new_height
);

    // input register
    logic              r_in_vld;
    logic              r_en;
    logic [RectW-1:0]  r_left, r_top, r_right, r_bottom, r_old_h;
    logic [PitchW-1:0] r_pitch;
    t_fmt              r_fmt;

    // result register
    logic              r_out_vld;
    logic              r_valid_res;
    logic [AdjW-1:0]   r_y_adj, r_uv_adj;
    logic [OffW-1:0]   r_y_off_x, r_y_off_y, r_uv_off_x, r_uv_off_y;
    logic [BlkW-1:0]   r_blk_left, r_blk_top;
    logic [RectW-1:0]  r_new_w, r_new_h;

    logic              n_valid_res;
    logic [AdjW-1:0]   n_y_adj, n_uv_adj;
    logic [OffW-1:0]   n_y_off_x, n_y_off_y, n_uv_off_x, n_uv_off_y;
    logic [BlkW-1:0]   n_blk_left, n_blk_top;
    logic [RectW-1:0]  n_new_w, n_new_h;

    t_px_shift                 bps;
    logic                      planar;
    logic [RectW-1:0]          left_fl, top_fl;
    logic [TilesYW-1:0]        tiles_y;
    logic [UvTilesYW-1:0]      uv_tiles_y;
    logic [TilesXW-1:0]        tiles_x;
    logic [OffW-1:0]           off_x;
    logic [PitchTW-1:0]        tiles_per_row;
    logic [TilesYW+PitchTW-1:0]   y_rows;
    logic [UvTilesYW+PitchTW-1:0] uv_rows;
    logic [AdjW-1:0]           col_adj;
    logic [OffW-1:0]           uv_unaligned;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start & ~busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_en     <= i_fill_enable;
            r_left   <= i_rect_left;
            r_top    <= i_rect_top;
            r_right  <= i_rect_right;
            r_bottom <= i_rect_bottom;
            r_pitch  <= i_row_pitch;
            r_old_h  <= i_surface_height;
            r_fmt    <= i_format_code;
        end
    end

    always_comb begin
        bps    = px_shift(r_fmt);
        planar = (r_fmt == FMT_PLANAR2) || (r_fmt == FMT_PLANAR1);

        left_fl = {r_left[RectW-1:BlkW], {BlkW{1'b0}}};
        top_fl  = {r_top[RectW-1:BlkW], {BlkW{1'b0}}};
        n_new_w = r_right - left_fl;
        n_new_h = r_bottom - top_fl;

        tiles_y    = r_top[RectW-1:TileRowsW];
        uv_tiles_y = r_top[RectW-1:TileRowsW+1];

        // tile column and dword offset of the block inside its tile
        case (bps)
            2'd2: begin
                tiles_x = r_left[RectW-1:TileBytesW-2];
                off_x   = {r_left[4], 4'b0000};
            end
            2'd1: begin
                tiles_x = {1'b0, r_left[RectW-1:TileBytesW-1]};
                off_x   = {r_left[5:4], 3'b000};
            end
            default: begin
                tiles_x = {2'b00, r_left[RectW-1:TileBytesW]};
                off_x   = {r_left[6:4], 2'b00};
            end
        endcase

        tiles_per_row = r_pitch[PitchW-1:TileBytesW];
        y_rows  = tiles_y * tiles_per_row;
        uv_rows = uv_tiles_y * tiles_per_row;
        col_adj = {{(AdjW-TilesXW-PageW){1'b0}}, tiles_x, {PageW{1'b0}}};

        // only the low five bits of the uv row count survive
        uv_unaligned = r_old_h[OffW-1:0] + r_bottom[OffW:1] - n_new_h[OffW:1];

        n_valid_res = 1'b1;
        n_y_adj     = {{(AdjW-TilesYW-PitchTW-PageW){1'b0}}, y_rows, {PageW{1'b0}}}
                      + col_adj;
        n_y_off_x   = off_x;
        n_y_off_y   = {r_top[BlkW], {BlkW{1'b0}}};
        n_uv_adj    = '0;
        n_uv_off_x  = '0;
        n_uv_off_y  = '0;
        if (planar) begin
            n_uv_adj   = {{(AdjW-UvTilesYW-PitchTW-PageW){1'b0}}, uv_rows, {PageW{1'b0}}}
                         + col_adj;
            n_uv_off_x = off_x;
            n_uv_off_y = uv_unaligned;
        end
        n_blk_left = r_left[BlkW-1:0];
        n_blk_top  = r_top[BlkW-1:0];

        if (!r_en) begin
            n_valid_res = 1'b0;
            n_y_adj     = '0;
            n_y_off_x   = '0;
            n_y_off_y   = '0;
            n_uv_adj    = '0;
            n_uv_off_x  = '0;
            n_uv_off_y  = '0;
            n_blk_left  = '0;
            n_blk_top   = '0;
            n_new_w     = '0;
            n_new_h     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_valid_res <= n_valid_res;
            r_y_adj     <= n_y_adj;
            r_y_off_x   <= n_y_off_x;
            r_y_off_y   <= n_y_off_y;
            r_uv_adj    <= n_uv_adj;
            r_uv_off_x  <= n_uv_off_x;
            r_uv_off_y  <= n_uv_off_y;
            r_blk_left  <= n_blk_left;
            r_blk_top   <= n_blk_top;
            r_new_w     <= n_new_w;
            r_new_h     <= n_new_h;
        end
    end

    assign o_strobe         = r_out_vld;
    assign o_valid_res      = r_valid_res;
    assign o_y_base_adjust  = r_y_adj;
    assign o_y_offset_x     = r_y_off_x;
    assign o_y_offset_y     = r_y_off_y;
    assign o_uv_base_adjust = r_uv_adj;
    assign o_uv_offset_x    = r_uv_off_x;
    assign o_uv_offset_y    = r_uv_off_y;
    assign o_block_left     = r_blk_left;
    assign o_block_top      = r_blk_top;
    assign o_new_width      = r_new_w;
    assign o_new_height     = r_new_h;

endmodule

[verif/tiled_surface_offset_rebase_tb.sv]
// testbench for the tiled surface offset rebase block: random rectangles checked by a scoreboard
`timescale 1ns / 100ps

module tiled_surface_offset_rebase_tb;
    import tsor_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_RECTS = 1750;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 100;

    typedef struct {
        logic              fill_enable;
        logic [RectW-1:0]  left;
        logic [RectW-1:0]  top;
        logic [RectW-1:0]  right;
        logic [RectW-1:0]  bottom;
        logic [PitchW-1:0] pitch;
        logic [RectW-1:0]  surface_height;
        t_fmt              fmt;
    } t_rect_req;

    typedef struct {
        logic             valid_res;
        logic [AdjW-1:0]  y_base_adjust;
        logic [OffW-1:0]  y_offset_x;
        logic [OffW-1:0]  y_offset_y;
        logic [AdjW-1:0]  uv_base_adjust;
        logic [OffW-1:0]  uv_offset_x;
        logic [OffW-1:0]  uv_offset_y;
        logic [BlkW-1:0]  block_left;
        logic [BlkW-1:0]  block_top;
        logic [RectW-1:0] new_width;
        logic [RectW-1:0] new_height;
    } t_rebase_offsets;

    class t_rebase_scoreboard;
        t_rebase_offsets expected_offsets[$];
        int error_count;
        int result_count;

        function new();
            error_count  = 0;
            result_count = 0;
        endfunction

        function int pending();
            return expected_offsets.size();
        endfunction

        // tile / block split of the rectangle origin
        function t_rebase_offsets rebase_offsets(t_rect_req r);
            t_rebase_offsets  o;
            int unsigned      shift;
            int unsigned      tiles_x;
            int unsigned      x_in_tile;
            int unsigned      unaligned_rows;
            longint unsigned  tiles_per_row;
            longint unsigned  y_adj;
            longint unsigned  uv_adj;
            o = '{default: '0};
            if (r.fill_enable !== 1'b1)
                return o;
            case (r.fmt)
                FMT_RGB4:    shift = 2;
                FMT_YUV2:    shift = 1;
                FMT_PLANAR2: shift = 1;
                default:     shift = 0;
            endcase
            o.valid_res  = 1'b1;
            o.new_width  = r.right - {r.left[RectW-1:BlkW], {BlkW{1'b0}}};
            o.new_height = r.bottom - {r.top[RectW-1:BlkW], {BlkW{1'b0}}};
            o.block_left = r.left[BlkW-1:0];
            o.block_top  = r.top[BlkW-1:0];
            o.y_offset_y = {r.top[TileRowsW-1], {BlkW{1'b0}}};

            tiles_x   = int'(r.left) >> (7 - shift);
            x_in_tile = ((int'(r.left) & ((128 >> shift) - 1)) & ~32'd15) >> (2 - shift);
            o.y_offset_x = x_in_tile[OffW-1:0];

            tiles_per_row = longint'(r.pitch) >> 7;
            y_adj = longint'(r.top >> TileRowsW) * tiles_per_row * 4096
                    + longint'(tiles_x) * 4096;
            o.y_base_adjust = y_adj[AdjW-1:0];

            if (r.fmt == FMT_PLANAR2 || r.fmt == FMT_PLANAR1) begin
                // uv rows follow the y plane, so only the low bits of the row count matter
                unaligned_rows = int'(r.surface_height) + int'(r.bottom) / 2
                                 - int'(o.new_height) / 2;
                o.uv_offset_y = unaligned_rows[OffW-1:0];
                o.uv_offset_x = x_in_tile[OffW-1:0];
                uv_adj = longint'(r.top >> (TileRowsW + 1)) * tiles_per_row * 4096
                         + longint'(tiles_x) * 4096;
                o.uv_base_adjust = uv_adj[AdjW-1:0];
            end
            return o;
        endfunction

        function void note_request(t_rect_req r);
            expected_offsets.push_back(rebase_offsets(r));
        endfunction

        task report_mismatch(string what);
            if (error_count < MAX_REPORTS)
                $display("[%0t] result %0d: %s", $time, result_count, what);
            error_count++;
        endtask

        task compare_field(string name, longint unsigned got, longint unsigned want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(t_rebase_offsets got);
            t_rebase_offsets want;
            if (expected_offsets.size() == 0) begin
                report_mismatch("result with no transfer outstanding");
            end else begin
                want = expected_offsets.pop_front();
                compare_field("valid_res", got.valid_res, want.valid_res);
                compare_field("y_base_adjust", got.y_base_adjust, want.y_base_adjust);
                compare_field("y_offset_x", got.y_offset_x, want.y_offset_x);
                compare_field("y_offset_y", got.y_offset_y, want.y_offset_y);
                compare_field("uv_base_adjust", got.uv_base_adjust, want.uv_base_adjust);
                compare_field("uv_offset_x", got.uv_offset_x, want.uv_offset_x);
                compare_field("uv_offset_y", got.uv_offset_y, want.uv_offset_y);
                compare_field("block_left", got.block_left, want.block_left);
                compare_field("block_top", got.block_top, want.block_top);
                compare_field("new_width", got.new_width, want.new_width);
                compare_field("new_height", got.new_height, want.new_height);
            end
            result_count++;
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_fill_enable;
    logic [RectW-1:0]  i_rect_left;
    logic [RectW-1:0]  i_rect_top;
    logic [RectW-1:0]  i_rect_right;
    logic [RectW-1:0]  i_rect_bottom;
    logic [PitchW-1:0] i_row_pitch;
    logic [RectW-1:0]  i_surface_height;
    logic [FmtW-1:0]   i_format_code;
    logic              o_strobe;
    logic              o_valid_res;
    logic [AdjW-1:0]   o_y_base_adjust;
    logic [OffW-1:0]   o_y_offset_x;
    logic [OffW-1:0]   o_y_offset_y;
    logic [AdjW-1:0]   o_uv_base_adjust;
    logic [OffW-1:0]   o_uv_offset_x;
    logic [OffW-1:0]   o_uv_offset_y;
    logic [BlkW-1:0]   o_block_left;
    logic [BlkW-1:0]   o_block_top;
    logic [RectW-1:0]  o_new_width;
    logic [RectW-1:0]  o_new_height;

    t_rebase_scoreboard sb;
    int unsigned        cycle_count;

    tiled_surface_offset_rebase dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_fill_enable    (i_fill_enable),
        .i_rect_left      (i_rect_left),
        .i_rect_top       (i_rect_top),
        .i_rect_right     (i_rect_right),
        .i_rect_bottom    (i_rect_bottom),
        .i_row_pitch      (i_row_pitch),
        .i_surface_height (i_surface_height),
        .i_format_code    (i_format_code),
        .o_strobe         (o_strobe),
        .o_valid_res      (o_valid_res),
        .o_y_base_adjust  (o_y_base_adjust),
        .o_y_offset_x     (o_y_offset_x),
        .o_y_offset_y     (o_y_offset_y),
        .o_uv_base_adjust (o_uv_base_adjust),
        .o_uv_offset_x    (o_uv_offset_x),
        .o_uv_offset_y    (o_uv_offset_y),
        .o_block_left     (o_block_left),
        .o_block_top      (o_block_top),
        .o_new_width      (o_new_width),
        .o_new_height     (o_new_height)
    );

    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side cannot be held off, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_rebase_offsets got;
        if (o_strobe === 1'b1) begin
            got.valid_res      = o_valid_res;
            got.y_base_adjust  = o_y_base_adjust;
            got.y_offset_x     = o_y_offset_x;
            got.y_offset_y     = o_y_offset_y;
            got.uv_base_adjust = o_uv_base_adjust;
            got.uv_offset_x    = o_uv_offset_x;
            got.uv_offset_y    = o_uv_offset_y;
            got.block_left     = o_block_left;
            got.block_top      = o_block_top;
            got.new_width      = o_new_width;
            got.new_height     = o_new_height;
            sb.check_result(got);
        end
    end

    function automatic t_rect_req make_rect(logic en, int l, int t, int r, int b,
                                            int p, int h, int f);
        t_rect_req q;
        q.fill_enable    = en;
        q.left           = l[RectW-1:0];
        q.top            = t[RectW-1:0];
        q.right          = r[RectW-1:0];
        q.bottom         = b[RectW-1:0];
        q.pitch          = p[PitchW-1:0];
        q.surface_height = h[RectW-1:0];
        q.fmt            = f[FmtW-1:0];
        return q;
    endfunction

    // drives one rectangle and holds it until the transfer happens
    task send_rect(input t_rect_req r);
        @(negedge i_clk);
        start            <= 1'b1;
        i_fill_enable    <= r.fill_enable;
        i_rect_left      <= r.left;
        i_rect_top       <= r.top;
        i_rect_right     <= r.right;
        i_rect_bottom    <= r.bottom;
        i_row_pitch      <= r.pitch;
        i_surface_height <= r.surface_height;
        i_format_code    <= r.fmt;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        sb.note_request(r);
    endtask

    task idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_rect_req random_rect();
        t_rect_req q;
        int        sel;
        q.fill_enable = ($urandom_range(0, 9) != 0);
        sel = $urandom_range(0, 9);
        // small origins in four of ten rectangles so that narrow surfaces are common, the rest anywhere
        if (sel < 4) begin
            q.left = RectW'($urandom_range(0, 255));
            q.top  = RectW'($urandom_range(0, 255));
        end else begin
            q.left = RectW'($urandom_range(0, 16383));
            q.top  = RectW'($urandom_range(0, 16383));
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            // corner may sit above or to the left of the origin
            q.right  = RectW'($urandom_range(0, 16383));
            q.bottom = RectW'($urandom_range(0, 16383));
        end else if (sel < 6) begin
            q.right  = RectW'(q.left + $urandom_range(0, 16383 - q.left < 300 ?
                                                      16383 - q.left : 300));
            q.bottom = RectW'(q.top + $urandom_range(0, 16383 - q.top < 300 ?
                                                     16383 - q.top : 300));
        end else begin
            q.right  = RectW'($urandom_range(q.left, 16383));
            q.bottom = RectW'($urandom_range(q.top, 16383));
        end
        if ($urandom_range(0, 9) < 7)
            q.pitch = {11'($urandom_range(0, 2047)), 7'd0};
        else
            q.pitch = PitchW'($urandom_range(0, 262143));
        q.surface_height = RectW'($urandom_range(0, 16383));
        q.fmt = FmtW'($urandom_range(0, 7));
        return q;
    endfunction

    initial begin
        t_rect_req directed[$];
        int        f;
        int        n;
        bit        burst;

        sb = new();
        cycle_count      = 0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_fill_enable    = 1'b0;
        i_rect_left      = '0;
        i_rect_top       = '0;
        i_rect_right     = '0;
        i_rect_bottom    = '0;
        i_row_pitch      = '0;
        i_surface_height = '0;
        i_format_code    = FMT_RGB4;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every format, including the unlisted codes, at an origin inside a tile
        for (f = 0; f < 8; f++)
            directed.push_back(make_rect(1'b1, 117, 53, 600, 400, 4096, 720, f));
        directed.push_back(make_rect(1'b0, 16383, 16383, 16383, 16383, 262143, 16383,
                                     int'(FMT_PLANAR2)));
        directed.push_back(make_rect(1'b1, 0, 0, 0, 0, 0, 0, int'(FMT_RGB4)));
        directed.push_back(make_rect(1'b1, 16383, 16383, 16383, 16383, 262143, 16383,
                                     int'(FMT_PLANAR1)));
        directed.push_back(make_rect(1'b1, 16383, 16383, 16383, 16383, 262143, 16383,
                                     int'(FMT_RGB4)));
        directed.push_back(make_rect(1'b1, 16383, 16383, 16383, 16383, 262143, 16383,
                                     int'(FMT_PLANAR2)));
        // right below left and bottom below top wrap
        directed.push_back(make_rect(1'b1, 500, 300, 10, 5, 8192, 1080, int'(FMT_YUV2)));
        // uv row count goes negative
        directed.push_back(make_rect(1'b1, 40, 16, 40, 0, 2048, 0, int'(FMT_PLANAR1)));
        directed.push_back(make_rect(1'b1, 40, 31, 80, 31, 2048, 0, int'(FMT_PLANAR2)));
        directed.push_back(make_rect(1'b1, 127, 32, 127, 32, 2048, 1, int'(FMT_PLANAR1)));
        directed.push_back(make_rect(1'b1, 128, 63, 255, 64, 2175, 8191, int'(FMT_OTHER)));
        directed.push_back(make_rect(1'b1, 31, 15, 32, 16, 127, 16383, int'(FMT_RGB4)));
        directed.push_back(make_rect(1'b1, 8191, 8192, 16383, 16383, 131072, 4096,
                                     int'(FMT_PLANAR2)));
        foreach (directed[i])
            send_rect(directed[i]);

        burst = 1'b0;
        for (n = 0; n < RANDOM_RECTS; n++) begin
            if (n % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            idle_cycles(pick_gap(burst));
            send_rect(random_rect());
        end
        idle_cycles(1);

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tsor_pkg.sv
hw/rtl/tiled_surface_offset_rebase.sv
verif/tiled_surface_offset_rebase_tb.sv
